### design/chbd_pkg.sv
// shared constants, types and coefficient rom for the cascaded half-band decimator
`timescale 1ns / 1ps
package chbd_pkg;

	localparam int SAMPLE_BITS   = 24;
	localparam int COEF_BITS     = 18;
	localparam int HALF_SPAN     = 31;
	localparam int SPAN          = 2 * HALF_SPAN + 1;
	localparam int MAX_STAGES    = 3;
	localparam int STAGE_BITS    = 2;
	localparam int FRAC_BITS     = COEF_BITS - 1;
	localparam int TAPS          = (HALF_SPAN + 1) / 2 + 1;
	localparam int TAP_BITS      = $clog2(TAPS);
	localparam int READS         = 2 * TAPS;
	localparam int RD_CNT_BITS   = $clog2(READS);
	localparam int PAIR_BITS     = SAMPLE_BITS + 1;
	localparam int PROD_BITS     = PAIR_BITS + COEF_BITS;
	localparam int ACC_BITS      = PROD_BITS + 1;
	localparam int PTR_BITS      = $clog2(SPAN);
	localparam int ROW_BITS      = 2 * SAMPLE_BITS;
	localparam int ROWS          = MAX_STAGES * SPAN;
	localparam int ROW_ADDR_BITS = $clog2(ROWS);
	localparam int RND_HALF      = 1 << (FRAC_BITS - 1);
	localparam int SAT_MAX       = (1 << (SAMPLE_BITS - 1)) - 1;
	localparam int SAT_MIN       = -(1 << (SAMPLE_BITS - 1));
	localparam int CFG_IDX_BITS  = 1;

	localparam logic [CFG_IDX_BITS-1:0] REG_STAGE_COUNT = 1'b0;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [COEF_BITS-1:0]   coef_t;

	typedef struct packed {
		logic                clr;
		logic                v;
		logic                second;
		logic [TAP_BITS-1:0] tap;
	} mac_ctl_t;

	// tap 0 is the centre tap halved, applied to the centre sample read twice
	function automatic coef_t coef_rom(input logic [TAP_BITS-1:0] tap);
		coef_t c;
		case (tap)
			5'd0:    c = 18'sd32768;
			5'd1:    c = 18'sd41515;
			5'd2:    c = -18'sd13298;
			5'd3:    c = 18'sd7364;
			5'd4:    c = -18'sd4659;
			5'd5:    c = 18'sd3074;
			5'd6:    c = -18'sd2040;
			5'd7:    c = 18'sd1334;
			5'd8:    c = -18'sd848;
			5'd9:    c = 18'sd518;
			5'd10:   c = -18'sd300;
			5'd11:   c = 18'sd163;
			5'd12:   c = -18'sd81;
			5'd13:   c = 18'sd36;
			5'd14:   c = -18'sd13;
			5'd15:   c = 18'sd4;
			default: c = '0;
		endcase
		return c;
	endfunction

	function automatic logic [ROW_ADDR_BITS-1:0] stage_base(input logic [STAGE_BITS-1:0] s);
		logic [ROW_ADDR_BITS-1:0] b;
		case (s)
			2'd1:    b = ROW_ADDR_BITS'(SPAN);
			2'd2:    b = ROW_ADDR_BITS'(2 * SPAN);
			default: b = '0;
		endcase
		return b;
	endfunction

endpackage

### design/cascaded_halfband_decimator.sv
// top level: sequencer, history store, apb register and stream ports
// an item is filtered through each active stage in turn, then passes through emit into the result register
// an item held as pending in a stage returns the sequencer to idle and ready with no result
// throughput: one item at a time; the single multiplier runs 34 products per stage
// the result register lets the next item in while a result waits
// reset clears control, pointers and pending flags; per-row valid bits make history read as zero
`timescale 1ns / 1ps
module cascaded_halfband_decimator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // left_sample, right_sample
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata    // out_left, out_right
);

	localparam int SB = chbd_pkg::SAMPLE_BITS;
	localparam int PB = chbd_pkg::PTR_BITS;
	localparam int AB = chbd_pkg::ROW_ADDR_BITS;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STAGE,
		ST_WR0,
		ST_WR1,
		ST_RD,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	state_t                                 state_q;
	logic [chbd_pkg::STAGE_BITS-1:0]        stage_q, n_q, stage_count_q;
	chbd_pkg::sample_t                      cur_l_q, cur_r_q;
	logic [chbd_pkg::MAX_STAGES-1:0]        pend_flag_q;
	chbd_pkg::sample_t                      pend_l_q [chbd_pkg::MAX_STAGES];
	chbd_pkg::sample_t                      pend_r_q [chbd_pkg::MAX_STAGES];
	logic [PB-1:0]                          hist_ptr_q [chbd_pkg::MAX_STAGES];
	logic [chbd_pkg::ROWS-1:0]              hist_v_q;
	logic [chbd_pkg::RD_CNT_BITS-1:0]       rd_cnt_q;
	logic                                   rd_v_s1, rd_second_s1, hv_s1;
	logic [chbd_pkg::TAP_BITS-1:0]          rd_tap_s1;
	logic                                   out_v_q;
	chbd_pkg::sample_t                      out_l_q, out_r_q;

	logic                                   cfg_wr;
	logic [PB-1:0]                          ptr, ptr_inc1, ptr_inc2, rd_back, rd_idx;
	logic [PB:0]                            rd_d;
	logic [chbd_pkg::TAP_BITS-1:0]          rd_tap;
	logic                                   rd_second;
	logic                                   ram_we, ram_re;
	logic [AB-1:0]                          ram_waddr, ram_raddr;
	logic [chbd_pkg::ROW_BITS-1:0]          ram_wdata, ram_rdata;
	chbd_pkg::sample_t                      row_l, row_r, res_l, res_r;
	chbd_pkg::mac_ctl_t                     mac_ctl;
	logic                                   mac_done;

	assign pready        = 1'b1;
	assign cfg_wr        = psel && penable && pwrite && pready &&
	                       (paddr[2] == chbd_pkg::REG_STAGE_COUNT);
	assign prdata        = (paddr[2] == chbd_pkg::REG_STAGE_COUNT) ?
	                       {30'd0, stage_count_q} : 32'd0;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {out_r_q, out_l_q};

	always_comb begin
		ptr       = hist_ptr_q[stage_q];
		ptr_inc1  = (ptr == PB'(chbd_pkg::SPAN - 1)) ? '0 : ptr + 1'b1;
		ptr_inc2  = (ptr >= PB'(chbd_pkg::SPAN - 2)) ? ptr - PB'(chbd_pkg::SPAN - 2) :
		            ptr + PB'(2);
		rd_tap    = rd_cnt_q[chbd_pkg::RD_CNT_BITS-1:1];
		rd_second = rd_cnt_q[0];
		// distance behind the newest sample
		if (rd_tap == '0) begin
			rd_back = PB'(chbd_pkg::HALF_SPAN);
		end else if (rd_second) begin
			rd_back = PB'(chbd_pkg::HALF_SPAN + 1) - {rd_tap, 1'b0};
		end else begin
			rd_back = PB'(chbd_pkg::HALF_SPAN - 1) + {rd_tap, 1'b0};
		end
		rd_d   = {1'b0, ptr} + (PB + 1)'(chbd_pkg::SPAN - 1) - {1'b0, rd_back};
		rd_idx = (rd_d >= (PB + 1)'(chbd_pkg::SPAN)) ?
		         PB'(rd_d - (PB + 1)'(chbd_pkg::SPAN)) : PB'(rd_d);

		ram_we    = (state_q == ST_WR0) || (state_q == ST_WR1);
		ram_waddr = chbd_pkg::stage_base(stage_q) +
		            AB'((state_q == ST_WR0) ? ptr : ptr_inc1);
		ram_wdata = (state_q == ST_WR0) ? {pend_r_q[stage_q], pend_l_q[stage_q]} :
		            {cur_r_q, cur_l_q};
		ram_re    = (state_q == ST_RD);
		ram_raddr = chbd_pkg::stage_base(stage_q) + AB'(rd_idx);

		row_l = hv_s1 ? ram_rdata[SB-1:0] : '0;
		row_r = hv_s1 ? ram_rdata[2*SB-1:SB] : '0;

		mac_ctl.clr    = (state_q == ST_WR1);
		mac_ctl.v      = rd_v_s1;
		mac_ctl.second = rd_second_s1;
		mac_ctl.tap    = rd_tap_s1;
	end

	chbd_ram #(
		.WIDTH(chbd_pkg::ROW_BITS),
		.DEPTH(chbd_pkg::ROWS)
	) u_hist (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	chbd_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mac_ctl),
		.row_left (row_l),
		.row_right(row_r),
		.res_left (res_l),
		.res_right(res_r),
		.done     (mac_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			stage_q       <= '0;
			n_q           <= '0;
			stage_count_q <= '0;
			cur_l_q       <= '0;
			cur_r_q       <= '0;
			pend_flag_q   <= '0;
			for (int i = 0; i < chbd_pkg::MAX_STAGES; i++) begin
				pend_l_q[i]   <= '0;
				pend_r_q[i]   <= '0;
				hist_ptr_q[i] <= '0;
			end
			hist_v_q      <= '0;
			rd_cnt_q      <= '0;
			rd_v_s1       <= 1'b0;
			rd_second_s1  <= 1'b0;
			rd_tap_s1     <= '0;
			hv_s1         <= 1'b0;
			out_v_q       <= 1'b0;
			out_l_q       <= '0;
			out_r_q       <= '0;
		end else begin
			rd_v_s1      <= ram_re;
			rd_second_s1 <= rd_second;
			rd_tap_s1    <= rd_tap;
			if (ram_re) begin
				hv_s1 <= hist_v_q[ram_raddr];
			end
			if (state_q == ST_EMIT && (!out_v_q || m_axis_tready)) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end

			if (cfg_wr) begin
				stage_count_q <= pwdata[chbd_pkg::STAGE_BITS-1:0];
				hist_v_q      <= '0;
				pend_flag_q   <= '0;
				for (int i = 0; i < chbd_pkg::MAX_STAGES; i++) begin
					hist_ptr_q[i] <= '0;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						cur_l_q <= s_axis_tdata[SB-1:0];
						cur_r_q <= s_axis_tdata[2*SB-1:SB];
						stage_q <= '0;
						n_q     <= stage_count_q;
						state_q <= ST_STAGE;
					end
				end
				ST_STAGE: begin
					if (stage_q == n_q) begin
						state_q <= ST_EMIT;
					end else if (!pend_flag_q[stage_q]) begin
						pend_l_q[stage_q]    <= cur_l_q;
						pend_r_q[stage_q]    <= cur_r_q;
						pend_flag_q[stage_q] <= 1'b1;
						state_q              <= ST_IDLE;
					end else begin
						state_q <= ST_WR0;
					end
				end
				ST_WR0: begin
					hist_v_q[ram_waddr]  <= 1'b1;
					pend_flag_q[stage_q] <= 1'b0;
					state_q              <= ST_WR1;
				end
				ST_WR1: begin
					hist_v_q[ram_waddr] <= 1'b1;
					hist_ptr_q[stage_q] <= ptr_inc2;
					rd_cnt_q            <= '0;
					state_q             <= ST_RD;
				end
				ST_RD: begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
					if (rd_cnt_q == chbd_pkg::RD_CNT_BITS'(chbd_pkg::READS - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (mac_done) begin
						cur_l_q <= res_l;
						cur_r_q <= res_r;
						stage_q <= stage_q + 1'b1;
						state_q <= ST_STAGE;
					end
				end
				ST_EMIT: begin
					if (!out_v_q || m_axis_tready) begin
						out_l_q <= cur_l_q;
						out_r_q <= cur_r_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> (state_q == ST_DRAIN))
		else $error("filter result outside drain");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("history read and write in the same cycle");

	a_stage_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STAGE) |-> (stage_q <= n_q))
		else $error("stage index past active count");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(hist_ptr_q[0] < PB'(chbd_pkg::SPAN)) && (hist_ptr_q[1] < PB'(chbd_pkg::SPAN)) &&
		(hist_ptr_q[2] < PB'(chbd_pkg::SPAN)))
		else $error("history pointer out of range");

	a_fill_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN && mac_done) |=> (state_q == ST_STAGE))
		else $error("sequencer did not advance after filter result");

endmodule

### design/chbd_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module chbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### design/chbd_mac.sv
// shared multiply-accumulate unit with pair adder and round/saturate
`timescale 1ns / 1ps
module chbd_mac (
	input  logic               clk,
	input  logic               arst_n,
	input  chbd_pkg::mac_ctl_t ctl,
	input  chbd_pkg::sample_t  row_left,
	input  chbd_pkg::sample_t  row_right,
	output chbd_pkg::sample_t  res_left,
	output chbd_pkg::sample_t  res_right,
	output logic               done
);

	localparam int QB = chbd_pkg::ACC_BITS - chbd_pkg::FRAC_BITS;

	chbd_pkg::sample_t                        hold_l_q, hold_r_q;
	logic signed [chbd_pkg::PAIR_BITS-1:0]    pair_l_s2, pair_r_s2;
	logic [chbd_pkg::TAP_BITS-1:0]            tap_s2;
	logic                                     pv_s2, pr_s2;
	logic signed [chbd_pkg::PROD_BITS-1:0]    prod_s3;
	logic                                     pv_s3, ch_s3, last_s3;
	logic signed [chbd_pkg::ACC_BITS-1:0]     acc_l_q, acc_r_q;
	logic                                     done_q;
	logic signed [chbd_pkg::PAIR_BITS-1:0]    mul_op;
	chbd_pkg::coef_t                          mul_c;
	logic signed [chbd_pkg::PROD_BITS-1:0]    prod;

	function automatic chbd_pkg::sample_t round_sat(
		input logic signed [chbd_pkg::ACC_BITS-1:0] acc
	);
		logic signed [chbd_pkg::ACC_BITS-1:0] rnd;
		logic signed [QB-1:0]                 q;
		chbd_pkg::sample_t                    r;
		rnd = acc + (acc[chbd_pkg::ACC_BITS-1] ?
			chbd_pkg::ACC_BITS'(chbd_pkg::RND_HALF - 1) :
			chbd_pkg::ACC_BITS'(chbd_pkg::RND_HALF));
		q = QB'(rnd >>> chbd_pkg::FRAC_BITS);
		if (q > QB'(chbd_pkg::SAT_MAX)) begin
			r = chbd_pkg::SAMPLE_BITS'(chbd_pkg::SAT_MAX);
		end else if (q < QB'(chbd_pkg::SAT_MIN)) begin
			r = chbd_pkg::SAMPLE_BITS'(chbd_pkg::SAT_MIN);
		end else begin
			r = chbd_pkg::SAMPLE_BITS'(q);
		end
		return r;
	endfunction

	// left product in the first cycle of a pair, right product in the next
	assign mul_op = pr_s2 ? pair_r_s2 : pair_l_s2;
	assign mul_c  = chbd_pkg::coef_rom(tap_s2);
	assign prod   = mul_op * mul_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_l_q  <= '0;
			hold_r_q  <= '0;
			pair_l_s2 <= '0;
			pair_r_s2 <= '0;
			tap_s2    <= '0;
			pv_s2     <= 1'b0;
			pr_s2     <= 1'b0;
			prod_s3   <= '0;
			pv_s3     <= 1'b0;
			ch_s3     <= 1'b0;
			last_s3   <= 1'b0;
			acc_l_q   <= '0;
			acc_r_q   <= '0;
			done_q    <= 1'b0;
		end else begin
			pv_s2 <= ctl.v && ctl.second;
			if (ctl.v && !ctl.second) begin
				hold_l_q <= row_left;
				hold_r_q <= row_right;
			end
			if (ctl.v && ctl.second) begin
				pair_l_s2 <= chbd_pkg::PAIR_BITS'(hold_l_q) + chbd_pkg::PAIR_BITS'(row_left);
				pair_r_s2 <= chbd_pkg::PAIR_BITS'(hold_r_q) + chbd_pkg::PAIR_BITS'(row_right);
				tap_s2    <= ctl.tap;
			end
			pr_s2   <= pv_s2;
			pv_s3   <= pv_s2 || pr_s2;
			ch_s3   <= pr_s2;
			last_s3 <= pr_s2 && (tap_s2 == chbd_pkg::TAP_BITS'(chbd_pkg::TAPS - 1));
			if (pv_s2 || pr_s2) begin
				prod_s3 <= prod;
			end
			if (ctl.clr) begin
				acc_l_q <= '0;
				acc_r_q <= '0;
			end else if (pv_s3) begin
				if (ch_s3) begin
					acc_r_q <= acc_r_q + chbd_pkg::ACC_BITS'(prod_s3);
				end else begin
					acc_l_q <= acc_l_q + chbd_pkg::ACC_BITS'(prod_s3);
				end
			end
			done_q <= pv_s3 && last_s3;
		end
	end

	assign res_left  = round_sat(acc_l_q);
	assign res_right = round_sat(acc_r_q);
	assign done      = done_q;

endmodule

### tb/sv/tb_top.sv
// testbench for the cascaded half-band decimator: directed and random stereo streams, apb setup
`timescale 1ns / 1ps
module tb_top;

	localparam logic [2:0] ADDR_STAGE_COUNT = {chbd_pkg::REG_STAGE_COUNT, 2'b00};
	localparam logic [2:0] ADDR_UNMAPPED    = 3'd4;
	localparam int         SETTLE_CYCLES    = 200;
	localparam int         SIDE_COUNT       = 16;
	localparam longint     CENTRE_WEIGHT    = 65536;

	typedef struct packed {
		chbd_pkg::sample_t right;
		chbd_pkg::sample_t left;
	} stereo_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;   // left_sample, right_sample
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;        // out_left, out_right

	int      src_idle_pct = 0;
	int      snk_idle_pct = 0;
	int      errors = 0;
	stereo_t decimated_pairs [$];

	// own copy of the cascade state
	int         hist_mem [chbd_pkg::MAX_STAGES][2][chbd_pkg::SPAN];
	int         wr_ptr [chbd_pkg::MAX_STAGES];
	bit         holding [chbd_pkg::MAX_STAGES];
	int         held [chbd_pkg::MAX_STAGES][2];
	logic [1:0] active_stages = 2'd0;

	cascaded_halfband_decimator u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint tap_weight(input int k);
		case (k)
			0:       return 41515;
			1:       return -13298;
			2:       return 7364;
			3:       return -4659;
			4:       return 3074;
			5:       return -2040;
			6:       return 1334;
			7:       return -848;
			8:       return 518;
			9:       return -300;
			10:      return 163;
			11:      return -81;
			12:      return 36;
			13:      return -13;
			14:      return 4;
			default: return 0;
		endcase
	endfunction

	function automatic void clear_cascade();
		for (int s = 0; s < chbd_pkg::MAX_STAGES; s++) begin
			wr_ptr[s] = 0;
			holding[s] = 1'b0;
			for (int c = 0; c < 2; c++) begin
				held[s][c] = 0;
				for (int i = 0; i < chbd_pkg::SPAN; i++)
					hist_mem[s][c][i] = 0;
			end
		end
	endfunction

	// back = 0 is the newest sample
	function automatic longint hist_at(input int s, input int c, input int back);
		return longint'(hist_mem[s][c][(wr_ptr[s] + 2 * chbd_pkg::SPAN - 1 - back) %
			chbd_pkg::SPAN]);
	endfunction

	function automatic int halfband_out(input int s, input int c);
		longint acc;
		longint q;
		longint half;
		int     off;
		half = longint'(1) << (chbd_pkg::FRAC_BITS - 1);
		acc = CENTRE_WEIGHT * hist_at(s, c, chbd_pkg::HALF_SPAN);
		for (int k = 0; k < SIDE_COUNT; k++) begin
			off = 2 * k + 1;
			acc += tap_weight(k) * (hist_at(s, c, chbd_pkg::HALF_SPAN + off) +
				hist_at(s, c, chbd_pkg::HALF_SPAN - off));
		end
		if (acc >= 0)
			q = (acc + half) >>> chbd_pkg::FRAC_BITS;
		else
			q = -((-acc + half) >>> chbd_pkg::FRAC_BITS);
		if (q > chbd_pkg::SAT_MAX)
			q = chbd_pkg::SAT_MAX;
		if (q < chbd_pkg::SAT_MIN)
			q = chbd_pkg::SAT_MIN;
		return int'(q);
	endfunction

	function automatic bit decimate_pair(input stereo_t in_pair, output stereo_t out_pair);
		int cur [2];
		int p;
		cur[0] = int'(in_pair.left);
		cur[1] = int'(in_pair.right);
		out_pair = '0;
		for (int s = 0; s < int'(active_stages); s++) begin
			if (!holding[s]) begin
				held[s][0] = cur[0];
				held[s][1] = cur[1];
				holding[s] = 1'b1;
				return 1'b0;
			end
			p = wr_ptr[s];
			for (int c = 0; c < 2; c++) begin
				hist_mem[s][c][p] = held[s][c];
				hist_mem[s][c][(p + 1) % chbd_pkg::SPAN] = cur[c];
			end
			wr_ptr[s] = (p + 2) % chbd_pkg::SPAN;
			for (int c = 0; c < 2; c++)
				cur[c] = halfband_out(s, c);
			holding[s] = 1'b0;
		end
		out_pair.left = chbd_pkg::sample_t'(cur[0]);
		out_pair.right = chbd_pkg::sample_t'(cur[1]);
		return 1'b1;
	endfunction

	function automatic chbd_pkg::sample_t pick_sample();
		case ($urandom_range(0, 9))
			0:       return chbd_pkg::sample_t'(chbd_pkg::SAT_MAX);
			1:       return chbd_pkg::sample_t'(chbd_pkg::SAT_MIN);
			2:       return '0;
			3:       return chbd_pkg::sample_t'($urandom_range(0, 31) - 16);
			default: return chbd_pkg::sample_t'($urandom);
		endcase
	endfunction

	// result checker and sink-side ready
	always @(posedge clk) begin
		stereo_t got;
		stereo_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (decimated_pairs.size() == 0) begin
				$display("%0t: unexpected transaction, expected none, actual %h", $time, got);
				errors++;
			end else begin
				want = decimated_pairs.pop_front();
				if (got.left !== want.left) begin
					$display("%0t: out_left mismatch, expected %0d, actual %0d",
						$time, want.left, got.left);
					errors++;
				end
				if (got.right !== want.right) begin
					$display("%0t: out_right mismatch, expected %0d, actual %0d",
						$time, want.right, got.right);
					errors++;
				end
			end
		end
		m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
	end

	task automatic send_pair(input chbd_pkg::sample_t l, input chbd_pkg::sample_t r);
		stereo_t in_pair;
		stereo_t out_pair;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		in_pair.left = l;
		in_pair.right = r;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= in_pair;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (decimate_pair(in_pair, out_pair))
			decimated_pairs = {decimated_pairs, out_pair};
	endtask

	task automatic wait_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (decimated_pairs.size() != 0)
			@(posedge clk);
	endtask

	task automatic settle();
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (addr == ADDR_STAGE_COUNT) begin
			active_stages = data[1:0];
			clear_cascade();
		end
	endtask

	task automatic check_stage_count();
		logic [31:0] data;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_STAGE_COUNT;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (data[1:0] !== active_stages) begin
			$display("%0t: stage_count read mismatch, expected %0d, actual %0d",
				$time, active_stages, data[1:0]);
			errors++;
		end
	endtask

	task automatic set_stages(input logic [1:0] count, input logic [29:0] upper);
		settle();
		apb_write(ADDR_STAGE_COUNT, {upper, count});
	endtask

	task automatic test_reset_passthrough();
		send_pair(chbd_pkg::sample_t'(chbd_pkg::SAT_MAX), chbd_pkg::sample_t'(chbd_pkg::SAT_MIN));
		send_pair(chbd_pkg::sample_t'(chbd_pkg::SAT_MIN), chbd_pkg::sample_t'(chbd_pkg::SAT_MAX));
		send_pair('0, '1);
		send_pair(24'sh555555, 24'shAAAAAA);
	endtask

	task automatic test_register_access();
		for (int v = 0; v < 4; v++) begin
			set_stages(v[1:0], '0);
			check_stage_count();
		end
		set_stages(2'd0, '1);
		check_stage_count();
	endtask

	task automatic test_single_stage_impulse();
		set_stages(2'd1, '0);
		send_pair(chbd_pkg::sample_t'(chbd_pkg::SAT_MAX), chbd_pkg::sample_t'(chbd_pkg::SAT_MIN));
		repeat (5) send_pair('0, '0);
		send_pair(chbd_pkg::sample_t'(chbd_pkg::SAT_MAX), chbd_pkg::sample_t'(chbd_pkg::SAT_MAX));
		send_pair(chbd_pkg::sample_t'(chbd_pkg::SAT_MIN), chbd_pkg::sample_t'(chbd_pkg::SAT_MIN));
	endtask

	task automatic test_unmapped_write();
		set_stages(2'd2, '0);
		send_pair(24'sd1000, -24'sd1000);
		settle();
		apb_write(ADDR_UNMAPPED, 32'd3);
		check_stage_count();
		send_pair(chbd_pkg::sample_t'(chbd_pkg::SAT_MAX), chbd_pkg::sample_t'(chbd_pkg::SAT_MIN));
		send_pair(-24'sd1, 24'sd1);
		send_pair(chbd_pkg::sample_t'(chbd_pkg::SAT_MIN), chbd_pkg::sample_t'(chbd_pkg::SAT_MAX));
	endtask

	task automatic test_full_cascade_dc();
		set_stages(2'd3, '0);
		repeat (8)
			send_pair(chbd_pkg::sample_t'(chbd_pkg::SAT_MAX),
				chbd_pkg::sample_t'(chbd_pkg::SAT_MIN));
	endtask

	task automatic test_random_stream(input logic [1:0] count, input int n_items,
		input bit pause_midway);
		set_stages(count, 30'($urandom));
		for (int i = 0; i < n_items; i++) begin
			if (pause_midway && i == n_items / 2)
				wait_results();
			send_pair(pick_sample(), pick_sample());
		end
	endtask

	task automatic test_random_phase(input int src_pct, input int snk_pct, input bit pressure);
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		test_random_stream(2'd3, 80, pressure);
		test_random_stream(2'd0, 30, 1'b0);
		test_random_stream(2'd2, 50, 1'b0);
		test_random_stream(2'd1, 40, 1'b0);
		test_random_stream(2'd3, 60, 1'b0);
	endtask

	initial begin
		clear_cascade();
		src_idle_pct = 34;
		snk_idle_pct = 62;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_passthrough();
		test_register_access();
		test_single_stage_impulse();
		test_unmapped_write();
		test_full_cascade_dc();
		test_random_phase(34, 62, 1'b1);
		test_random_phase(62, 34, 1'b0);
		test_random_phase(0, 0, 1'b0);
		settle();
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
